// ===== hw/rtl/ptt_pkg.sv =====
// ptt_pkg: shared types, field widths and codes for the page table translator
// no dependencies; imported by ptt_ctrl, ptt_datapath and page_table_translate
package ptt_pkg;

    // field widths
    localparam int PAGE_W   = 6;
    localparam int OFFSET_W = 12;
    localparam int FRAME_W  = 5;
    localparam int PSIZE_W  = 13;
    localparam int ADDR_W   = 17;
    localparam int ENTRY_W  = 9;
    localparam int IN_W     = 32;
    localparam int OUT_W    = 32;

    // entry layout
    localparam int BIT_PRESENT    = 5;
    localparam int BIT_PROTECT    = 6;
    localparam int BIT_MODIFIED   = 7;
    localparam int BIT_REFERENCED = 8;

    localparam logic [ENTRY_W-1:0] ENTRY_ONES    = '1;
    localparam logic [ADDR_W-1:0]  ADDR_MAX      = '1;
    localparam logic [PSIZE_W-1:0] PAGE_SIZE_RST = 13'd4096;
    localparam int                 PAGES_DEF     = 64;

    typedef enum logic [1:0] {
        KIND_TRANSLATE = 2'd0,
        KIND_MAP       = 2'd1,
        KIND_READ      = 2'd2,
        KIND_UPDATE    = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        STS_OK       = 2'd0,
        STS_UNMAPPED = 2'd1,
        STS_PROTECT  = 2'd2,
        STS_FAULT    = 2'd3
    } t_status;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic capture;  // latch word and launch table read
        logic commit;   // write back entry and load output register
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic out_full; // output register holds a word not taken this cycle
    } t_stat;

endpackage

// ===== hw/rtl/page_table_translate.sv =====
// page_table_translate: top level of the single-level page table translator
// depends on ptt_pkg, ptt_ctrl and ptt_datapath
//
// channel   dir  handshake                         payload
// s_axis    in   s_axis_tvalid / s_axis_tready     tuser kind, tdata request word
// m_axis    out  m_axis_tvalid / m_axis_tready     tdata result word
// cfg       in   i_cfg_valid / o_cfg_ready         i_cfg_data page size
//
// each word takes a registered table read, then the update, address multiply-add
// and write back through the single table port
// the output register lets the next word be taken while a result waits
// if the result is not taken the block holds in its update cycle
// reset (synchronous, active low) clears all mapped bits and sets page size to 4096
// the config port is always ready; the user must write it only while the block is idle (not enforced)
module page_table_translate
    import ptt_pkg::*;
#(
    parameter int PAGES = PAGES_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    // request words
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    // tdata: page_number[5:0], offset[17:6], write_access[18], frame_number[23:19],
    //        protect[24], absent[25], zero[31:26]
    input  logic [IN_W-1:0]  s_axis_tdata,
    // tuser: kind[1:0]
    input  logic [1:0]       s_axis_tuser,
    // result words
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    // tdata: status[1:0], physical_address[18:2], referenced[19], modified[20],
    //        read_only[21], present[22], frame[27:23], zero[31:28]
    output logic [OUT_W-1:0] m_axis_tdata,
    // page size register
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [PSIZE_W-1:0] i_cfg_data
);

    t_cmd  cmd;
    t_stat stat;

    assign o_cfg_ready = 1'b1;

    ptt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    ptt_datapath #(
        .PAGES (PAGES)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_kind      (t_kind'(s_axis_tuser)),
        .i_page      (s_axis_tdata[5:0]),
        .i_offset    (s_axis_tdata[17:6]),
        .i_write     (s_axis_tdata[18]),
        .i_frame     (s_axis_tdata[23:19]),
        .i_protect   (s_axis_tdata[24]),
        .i_absent    (s_axis_tdata[25]),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (m_axis_tdata)
    );

endmodule

// ===== hw/rtl/ptt_ctrl.sv =====
// ptt_ctrl: two-state sequencer for the page table translator
// depends on ptt_pkg (t_state, t_cmd, t_stat)
module ptt_ctrl
    import ptt_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (!i_stat.out_full) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready     = 1'b0;
        o_cmd.capture  = 1'b0;
        o_cmd.commit   = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.capture = i_in_valid;
            end
            ST_EXEC: begin
                o_cmd.commit = !i_stat.out_full;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    a_capture_to_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.capture |=> r_state == ST_EXEC)
        else $error("capture did not move to exec");

    a_hold_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EXEC && i_stat.out_full) |=> r_state == ST_EXEC)
        else $error("left exec while output register was full");

    a_commit_in_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |-> r_state == ST_EXEC)
        else $error("commit outside exec");

endmodule

// ===== hw/rtl/ptt_datapath.sv =====
// ptt_datapath: page table memory, mapped bits, translation arithmetic and output register
// depends on ptt_pkg (widths, entry layout, kind and status codes, t_cmd, t_stat)
module ptt_datapath
    import ptt_pkg::*;
#(
    parameter int PAGES = PAGES_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cmd                i_cmd,
    output t_stat               o_stat,
    // input word fields
    input  t_kind               i_kind,
    input  logic [PAGE_W-1:0]   i_page,
    input  logic [OFFSET_W-1:0] i_offset,
    input  logic                i_write,
    input  logic [FRAME_W-1:0]  i_frame,
    input  logic                i_protect,
    input  logic                i_absent,
    // configuration
    input  logic                i_cfg_we,
    input  logic [PSIZE_W-1:0]  i_cfg_data,
    // output register
    input  logic                i_out_ready,
    output logic                o_out_valid,
    output logic [OUT_W-1:0]    o_out_data
);

    localparam int REACH = 2 ** PAGE_W;
    localparam int DEPTH = (PAGES < REACH) ? PAGES : REACH;
    localparam int IDX_W = $clog2(DEPTH);

    logic [ENTRY_W-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0]   r_mapped;
    logic [PSIZE_W-1:0] r_page_size;

    // captured word
    t_kind               r_kind;
    logic [IDX_W-1:0]    r_idx;
    logic                r_in_range;
    logic                r_hit;
    logic [OFFSET_W-1:0] r_offset;
    logic                r_write;
    logic [FRAME_W-1:0]  r_frame;
    logic                r_protect;
    logic                r_absent;
    logic [ENTRY_W-1:0]  r_rd_entry;

    // output register
    logic                r_out_valid;
    t_status             r_out_status;
    logic [ADDR_W-1:0]   r_out_addr;
    logic [ENTRY_W-1:0]  r_out_entry;

    logic [IDX_W-1:0]    in_idx;
    logic                in_range;
    logic [ENTRY_W-1:0]  cur_e;
    logic [ENTRY_W-1:0]  n_e;
    t_status             n_status;
    logic                n_addr_sel;
    logic                mem_we;
    logic                map_we;
    logic [FRAME_W+PSIZE_W-1:0] prod;
    logic [FRAME_W+PSIZE_W:0]   sum;
    logic [ADDR_W-1:0]   addr_sat;

    assign in_idx   = IDX_W'(i_page);
    assign in_range = ({{(32-PAGE_W){1'b0}}, i_page} < 32'(PAGES));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_page_size <= PAGE_SIZE_RST;
        end else if (i_cfg_we) begin
            r_page_size <= i_cfg_data;
        end
    end

    // capture the word and read the table
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_kind     <= i_kind;
            r_idx      <= in_idx;
            r_in_range <= in_range;
            r_hit      <= in_range && r_mapped[in_idx];
            r_offset   <= i_offset;
            r_write    <= i_write;
            r_frame    <= i_frame;
            r_protect  <= i_protect;
            r_absent   <= i_absent;
            r_rd_entry <= r_mem[in_idx];
        end
    end

    // entry update and status
    always_comb begin
        cur_e      = r_hit ? r_rd_entry : ENTRY_ONES;
        n_e        = cur_e;
        n_status   = STS_OK;
        n_addr_sel = 1'b0;
        mem_we     = 1'b0;
        map_we     = 1'b0;
        if (r_kind == KIND_MAP) begin
            n_e = {2'b00, r_protect, 1'b1, r_frame};
            mem_we = r_in_range;
            map_we = r_in_range;
        end else if (!r_hit) begin
            n_status = STS_UNMAPPED;
        end else begin
            unique case (r_kind)
                KIND_TRANSLATE: begin
                    if (!cur_e[BIT_PRESENT]) begin
                        n_status = STS_FAULT;
                    end else if (cur_e[BIT_PROTECT] && r_write) begin
                        n_status = STS_PROTECT;
                    end else begin
                        n_e[BIT_REFERENCED] = 1'b1;
                        if (r_write) begin
                            n_e[BIT_MODIFIED] = 1'b1;
                        end
                        n_addr_sel = 1'b1;
                        mem_we     = 1'b1;
                    end
                end
                KIND_UPDATE: begin
                    if (r_absent) begin
                        n_e[BIT_PRESENT] = 1'b0;
                    end else begin
                        n_e[BIT_REFERENCED] = 1'b1;
                        if (r_write) begin
                            n_e[BIT_MODIFIED] = 1'b1;
                        end
                    end
                    mem_we = 1'b1;
                end
                KIND_READ: begin
                    n_status = STS_OK;
                end
                default: begin
                    n_status = STS_OK;
                end
            endcase
        end
    end

    // frame * page_size + offset, saturating
    assign prod     = (FRAME_W+PSIZE_W)'(n_e[FRAME_W-1:0]) * (FRAME_W+PSIZE_W)'(r_page_size);
    assign sum      = (FRAME_W+PSIZE_W+1)'(prod) + (FRAME_W+PSIZE_W+1)'(r_offset);
    assign addr_sat = (sum > (FRAME_W+PSIZE_W+1)'(ADDR_MAX)) ? ADDR_MAX : sum[ADDR_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && mem_we) begin
            r_mem[r_idx] <= n_e;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mapped <= '0;
        end else if (i_cmd.commit && map_we) begin
            r_mapped[r_idx] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out_status <= n_status;
            r_out_addr   <= n_addr_sel ? addr_sat : '0;
            r_out_entry  <= n_e;
        end
    end

    assign o_stat.out_full = r_out_valid && !i_out_ready;
    assign o_out_valid     = r_out_valid;
    assign o_out_data      = {4'b0000,
                              r_out_entry[FRAME_W-1:0],
                              r_out_entry[BIT_PRESENT],
                              r_out_entry[BIT_PROTECT],
                              r_out_entry[BIT_MODIFIED],
                              r_out_entry[BIT_REFERENCED],
                              r_out_addr,
                              r_out_status};

    a_map_sets_mapped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit && map_we) |=> r_mapped[$past(r_idx)])
        else $error("map did not set the mapped bit");

    a_addr_only_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status != STS_OK) |-> r_out_addr == '0)
        else $error("nonzero address with failing status");

    a_unmapped_ones: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status == STS_UNMAPPED) |-> r_out_entry == ENTRY_ONES)
        else $error("unmapped result does not read as all ones");

endmodule

// ===== tb/page_table_translate_test.sv =====
// page_table_translate_test: self-checking bench for the page table translator
// depends on ptt_pkg and page_table_translate; predicts every result word and
// checks it field by field under several idle, stall and page size settings
`timescale 1ns / 100ps

module page_table_translate_test;
    import ptt_pkg::*;

    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 300;
    localparam int CYCLE_LIMIT   = 300000;
    localparam int MAX_REPORTS   = 10;

    // request fields, page_number in the low bits
    typedef struct packed {
        logic               absent;
        logic               protect;
        logic [FRAME_W-1:0] frame_number;
        logic               write_access;
        logic [OFFSET_W-1:0] offset;
        logic [PAGE_W-1:0]  page_number;
    } req_fields_t;

    // result fields, status in the low bits
    typedef struct packed {
        logic [FRAME_W-1:0] frame;
        logic               present;
        logic               read_only;
        logic               modified;
        logic               referenced;
        logic [ADDR_W-1:0]  physical_address;
        t_status            status;
    } result_t;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [IN_W-1:0]   s_axis_tdata = '0;
    logic [1:0]        s_axis_tuser = KIND_READ;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [OUT_W-1:0]  m_axis_tdata;
    logic              i_cfg_valid = 1'b0;
    logic              o_cfg_ready;
    logic [PSIZE_W-1:0] i_cfg_data = PAGE_SIZE_RST;

    // predictor state
    logic [ENTRY_W-1:0] entry_table [PAGES_DEF];
    logic               entry_written [PAGES_DEF];
    logic [PSIZE_W-1:0] page_bytes;

    result_t     expected_results [$];
    int          mismatches = 0;
    int unsigned cycle_count = 0;

    // idling controls
    int          send_idle_pct = 0;
    int          stall_pct = 0;
    logic        hold_toggle = 1'b0;
    logic        hold_seen = 1'b0;
    int          hold_left = 0;
    int          map_page_max = 47;

    page_table_translate uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // result of one request, updating the table copy as the block would
    function automatic result_t apply_request(input t_kind kind, input req_fields_t req);
        result_t            res;
        logic [ENTRY_W-1:0] ent;
        logic               hit;
        int unsigned        addr;
        hit = entry_written[req.page_number];
        ent = hit ? entry_table[req.page_number] : ENTRY_ONES;
        res = '0;
        res.status = STS_OK;
        if (kind == KIND_MAP) begin
            // fresh entry: present, no modified or referenced
            ent = '0;
            ent[BIT_PRESENT] = 1'b1;
            ent[BIT_PROTECT] = req.protect;
            ent[FRAME_W-1:0] = req.frame_number;
            entry_table[req.page_number] = ent;
            entry_written[req.page_number] = 1'b1;
        end else if (!hit) begin
            res.status = STS_UNMAPPED;
            ent = ENTRY_ONES;
        end else if (kind == KIND_TRANSLATE) begin
            // present is checked before protection
            if (!ent[BIT_PRESENT]) begin
                res.status = STS_FAULT;
            end else if (ent[BIT_PROTECT] && req.write_access) begin
                res.status = STS_PROTECT;
            end else begin
                ent[BIT_REFERENCED] = 1'b1;
                if (req.write_access) ent[BIT_MODIFIED] = 1'b1;
                entry_table[req.page_number] = ent;
                addr = int'(ent[FRAME_W-1:0]) * int'(page_bytes) + int'(req.offset);
                // saturate at the top of the address range
                res.physical_address = (addr > ADDR_MAX) ? ADDR_MAX : addr[ADDR_W-1:0];
            end
        end else if (kind == KIND_UPDATE) begin
            if (req.absent) begin
                ent[BIT_PRESENT] = 1'b0;
            end else begin
                ent[BIT_REFERENCED] = 1'b1;
                if (req.write_access) ent[BIT_MODIFIED] = 1'b1;
            end
            entry_table[req.page_number] = ent;
        end
        res.referenced = ent[BIT_REFERENCED];
        res.modified   = ent[BIT_MODIFIED];
        res.read_only  = ent[BIT_PROTECT];
        res.present    = ent[BIT_PRESENT];
        res.frame      = ent[FRAME_W-1:0];
        return res;
    endfunction

    // result side: stalls at random, or holds off for a long stretch on request
    always @(posedge i_clk) begin
        if (hold_toggle != hold_seen) begin
            hold_seen <= hold_toggle;
            hold_left <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // compare each result word with the oldest prediction
    always @(posedge i_clk) begin
        result_t got;
        result_t want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = result_t'(m_axis_tdata[$bits(result_t)-1:0]);
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected result word %h at cycle %0d", m_axis_tdata, cycle_count);
            end else begin
                want = expected_results.pop_front();
                if (got.status !== want.status
                        || got.physical_address !== want.physical_address
                        || got.referenced !== want.referenced
                        || got.modified !== want.modified
                        || got.read_only !== want.read_only
                        || got.present !== want.present
                        || got.frame !== want.frame) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("mismatch at cycle %0d: sts/addr/ref/mod/ro/pres/frame", cycle_count);
                        $display("  expected %0d %0d %0d %0d %0d %0d %0d", want.status,
                            want.physical_address, want.referenced, want.modified,
                            want.read_only, want.present, want.frame);
                        $display("  actual   %0d %0d %0d %0d %0d %0d %0d", got.status,
                            got.physical_address, got.referenced, got.modified,
                            got.read_only, got.present, got.frame);
                    end
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // offer one word and predict its result once it is taken
    // valid stays high afterwards so back-to-back words need no extra edge
    task automatic send_request(input t_kind kind, input req_fields_t req);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_W'(req);
        s_axis_tuser  <= kind;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        expected_results.push_back(apply_request(kind, req));
    endtask

    task automatic send_fields(input t_kind kind, input int page, input int offs,
                               input bit wr, input int frame, input bit prot, input bit absent);
        req_fields_t req;
        req.page_number  = PAGE_W'(page);
        req.offset       = OFFSET_W'(offs);
        req.write_access = wr;
        req.frame_number = FRAME_W'(frame);
        req.protect      = prot;
        req.absent       = absent;
        send_request(kind, req);
    endtask

    // stop offering, wait for every result, then let the pipeline settle
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_page_size(input logic [PSIZE_W-1:0] bytes);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= bytes;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        page_bytes = bytes;
    endtask

    task automatic set_idling(input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        stall_pct <= recv_pct;
    endtask

    // untouched pages answer unmapped with all ones and stay unchanged
    task automatic test_unmapped_pages();
        send_fields(KIND_READ, 3, 0, 0, 0, 0, 0);
        send_fields(KIND_TRANSLATE, 3, 4095, 1, 0, 0, 0);
        send_fields(KIND_UPDATE, 3, 0, 1, 0, 0, 0);
        send_fields(KIND_UPDATE, 3, 0, 0, 0, 0, 1);
        send_fields(KIND_READ, 3, 0, 0, 0, 0, 0);
        drain();
    endtask

    // map, translate with reads and writes, read back, remap
    task automatic test_map_and_translate();
        send_fields(KIND_MAP, 0, 0, 0, 31, 0, 0);
        send_fields(KIND_MAP, 63, 0, 0, 0, 1, 0);
        send_fields(KIND_TRANSLATE, 0, 4095, 0, 0, 0, 0);
        send_fields(KIND_TRANSLATE, 0, 0, 1, 0, 0, 0);
        send_fields(KIND_READ, 0, 0, 0, 0, 0, 0);
        send_fields(KIND_TRANSLATE, 63, 4095, 0, 0, 0, 0);
        send_fields(KIND_UPDATE, 63, 0, 1, 0, 0, 0);
        send_fields(KIND_READ, 63, 0, 0, 0, 0, 0);
        send_fields(KIND_MAP, 0, 0, 0, 21, 0, 0);
        send_fields(KIND_READ, 0, 0, 0, 0, 0, 0);
        drain();
    endtask

    // write to a protected page, and a page made absent (fault wins)
    task automatic test_faults();
        send_fields(KIND_TRANSLATE, 63, 17, 1, 0, 0, 0);
        send_fields(KIND_MAP, 5, 0, 0, 17, 1, 0);
        send_fields(KIND_UPDATE, 5, 0, 0, 0, 0, 1);
        send_fields(KIND_TRANSLATE, 5, 100, 1, 0, 0, 0);
        send_fields(KIND_TRANSLATE, 5, 100, 0, 0, 0, 0);
        send_fields(KIND_READ, 5, 0, 0, 0, 0, 0);
        drain();
    endtask

    // zero page size, saturating sizes and the smallest size
    task automatic test_page_size_edges();
        write_page_size(0);
        send_fields(KIND_MAP, 6, 0, 0, 31, 0, 0);
        send_fields(KIND_TRANSLATE, 6, 1234, 0, 0, 0, 0);
        write_page_size(8191);
        send_fields(KIND_TRANSLATE, 6, 4095, 1, 0, 0, 0);
        write_page_size(4097);
        send_fields(KIND_TRANSLATE, 6, 4095, 0, 0, 0, 0);
        send_fields(KIND_MAP, 7, 0, 0, 1, 0, 0);
        send_fields(KIND_TRANSLATE, 7, 3, 0, 0, 0, 0);
        write_page_size(1);
        send_fields(KIND_TRANSLATE, 6, 4095, 0, 0, 0, 0);
        drain();
    endtask

    // mixed traffic, mostly on a small set of hot pages so translates hit
    task automatic test_random_traffic(input int count, input int send_pct, input int recv_pct,
                                       input logic [PSIZE_W-1:0] bytes);
        req_fields_t req;
        t_kind       kind;
        logic [31:0] rnd;
        int          pick;
        write_page_size(bytes);
        set_idling(send_pct, recv_pct);
        for (int i = 0; i < count; i++) begin
            rnd  = $urandom;
            req  = rnd[$bits(req_fields_t)-1:0];
            pick = $urandom_range(0, 99);
            if (pick < 40)      kind = KIND_TRANSLATE;
            else if (pick < 60) kind = KIND_MAP;
            else if (pick < 75) kind = KIND_READ;
            else                kind = KIND_UPDATE;
            if (kind == KIND_MAP)
                req.page_number = PAGE_W'($urandom_range(0, map_page_max));
            else if ($urandom_range(0, 3) != 0)
                req.page_number = PAGE_W'($urandom_range(0, 15));
            if (kind == KIND_UPDATE)
                req.absent = ($urandom_range(0, 99) < 30);
            send_request(kind, req);
        end
        drain();
    endtask

    // receiver holds off long enough for the block to fill and stall its input
    task automatic test_backpressure();
        req_fields_t req;
        logic [31:0] rnd;
        write_page_size(512);
        set_idling(0, 0);
        hold_toggle <= ~hold_toggle;
        for (int i = 0; i < 40; i++) begin
            rnd = $urandom;
            req = rnd[$bits(req_fields_t)-1:0];
            req.page_number = PAGE_W'($urandom_range(0, 15));
            send_request(KIND_TRANSLATE, req);
        end
        drain();
    endtask

    initial begin
        for (int p = 0; p < PAGES_DEF; p++) begin
            entry_table[p]   = ENTRY_ONES;
            entry_written[p] = 1'b0;
        end
        page_bytes = PAGE_SIZE_RST;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_unmapped_pages();
        test_map_and_translate();
        test_faults();
        test_page_size_edges();
        test_random_traffic(275, 0, 0, 4096);
        test_random_traffic(275, 58, 0, 13'($urandom_range(1, 4096)));
        test_random_traffic(275, 0, 58, 1);
        map_page_max = 63;
        test_random_traffic(275, 29, 29, 8191);
        test_backpressure();

        drain();
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
